FILE: rtl/dpa_pkg.sv
// Shared types and codes for the dining philosophers allocator.
// No dependencies; imported by every module of the block.
package dpa_pkg;

    localparam int DINERS_DEF = 5;
    localparam int IDX_W      = 3;
    localparam int OWN_W      = 4;
    localparam int MASK_W     = 5;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_OUT_W = 24;

    localparam logic [1:0] ST_THINKING = 2'd0;
    localparam logic [1:0] ST_HUNGRY   = 2'd1;
    localparam logic [1:0] ST_EATING   = 2'd2;

    localparam logic [2:0] OC_RELEASED     = 3'd0;
    localparam logic [2:0] OC_STARTED      = 3'd1;
    localparam logic [2:0] OC_WAITS_SECOND = 3'd2;
    localparam logic [2:0] OC_FIRST_BUSY   = 3'd3;
    localparam logic [2:0] OC_REFUSED      = 3'd4;

    localparam logic [1:0] STRAT_NAIVE   = 2'd0;
    localparam logic [1:0] STRAT_ASYM    = 2'd1;
    localparam logic [1:0] STRAT_ARB     = 2'd2;
    localparam logic [1:0] STRAT_INVALID = 2'd3;

    // per-lane effect of triggering that diner; resource slot 0 is its left
    // resource, slot 1 its right resource
    typedef struct packed {
        logic [1:0]            st;
        logic [2:0]            oc;
        logic                  hung;
        logic                  lstart;
        logic                  rstart;
        logic                  we_m1;
        logic                  we_p2;
        logic [1:0]            we;
        logic [1:0]            v;
        logic [1:0][OWN_W-1:0] own;
    } t_lane_fx;

    // result, last field in the lowest bits
    typedef struct packed {
        logic              dead;
        logic [MASK_W-1:0] hmask;
        logic [MASK_W-1:0] emask;
        logic              rstart;
        logic              lstart;
        logic              hung;
        logic [2:0]        oc;
        logic [1:0]        st;
    } t_result;

endpackage

FILE: rtl/dpa_lane.sv
// Step logic for one diner, assuming this diner is the one triggered.
// Uses dpa_pkg; instantiated once per diner by dpa_table.
module dpa_lane
    import dpa_pkg::*;
#(
    parameter int DINERS = DINERS_DEF,
    parameter int LANE   = 0
) (
    input  logic [1:0]            i_strategy,
    input  logic [4:0][1:0]       i_st_nb,   // states of diners LANE-2 .. LANE+2
    input  logic [1:0]            i_ov,      // resources LANE, LANE+1 owned
    input  logic [1:0][OWN_W-1:0] i_own,
    output t_lane_fx              o_fx
);

    localparam int LEFT  = (LANE + DINERS - 1) % DINERS;
    localparam int RIGHT = (LANE + 1) % DINERS;
    localparam logic [OWN_W-1:0] OWN_SELF  = OWN_W'(LANE);
    localparam logic [OWN_W-1:0] OWN_LEFT  = OWN_W'(LEFT);
    localparam logic [OWN_W-1:0] OWN_RIGHT = OWN_W'(RIGHT);

    logic [1:0]            w_sll, w_sl, w_s, w_sr, w_srr;
    logic                  w_first, w_second, w_held_f;
    logic [1:0]            w_we, w_v;
    logic [1:0][OWN_W-1:0] w_own;
    logic                  w_ls, w_rs, w_hung;
    logic [1:0]            w_st;
    logic [2:0]            w_oc;

    assign w_sll = i_st_nb[0];
    assign w_sl  = i_st_nb[1];
    assign w_s   = i_st_nb[2];
    assign w_sr  = i_st_nb[3];
    assign w_srr = i_st_nb[4];

    // odd diners go right first under the asymmetric order
    assign w_first  = (i_strategy == STRAT_ASYM) && (LANE % 2 == 1);
    assign w_second = ~w_first;
    assign w_held_f = i_ov[w_first] && (i_own[w_first] == OWN_SELF);

    always_comb begin
        w_we   = '0;
        w_v    = '0;
        w_own  = '0;
        w_ls   = 1'b0;
        w_rs   = 1'b0;
        w_hung = 1'b0;
        w_st   = ST_HUNGRY;
        w_oc   = OC_FIRST_BUSY;
        if (w_s == ST_EATING) begin
            w_st = ST_THINKING;
            w_oc = OC_RELEASED;
            w_we = 2'b11;
            if (i_strategy == STRAT_ARB) begin
                w_ls = (w_sl == ST_HUNGRY) && (w_sll != ST_EATING);
                // on a ring of three the far neighbour is the left one
                w_rs = (w_sr == ST_HUNGRY) && (w_srr != ST_EATING) &&
                       !((DINERS == 3) && w_ls);
                if (w_ls) begin
                    w_v[0]   = 1'b1;
                    w_own[0] = OWN_LEFT;
                end
                if (w_rs) begin
                    w_v[1]   = 1'b1;
                    w_own[1] = OWN_RIGHT;
                end
            end
        end else begin
            w_hung = (w_s == ST_THINKING);
            if (i_strategy == STRAT_ARB) begin
                if (w_sl != ST_EATING && w_sr != ST_EATING) begin
                    w_st  = ST_EATING;
                    w_oc  = OC_STARTED;
                    w_we  = 2'b11;
                    w_v   = 2'b11;
                    w_own = {OWN_SELF, OWN_SELF};
                end else begin
                    w_oc = OC_REFUSED;
                end
            end else if (!w_held_f && i_ov[w_first]) begin
                w_oc = OC_FIRST_BUSY;
            end else begin
                w_we[w_first]  = 1'b1;
                w_v[w_first]   = 1'b1;
                w_own[w_first] = OWN_SELF;
                if (!i_ov[w_second]) begin
                    w_we[w_second]  = 1'b1;
                    w_v[w_second]   = 1'b1;
                    w_own[w_second] = OWN_SELF;
                    w_st = ST_EATING;
                    w_oc = OC_STARTED;
                end else begin
                    w_oc = OC_WAITS_SECOND;
                end
            end
        end
    end

    always_comb begin
        o_fx        = '0;
        o_fx.st     = w_st;
        o_fx.oc     = w_oc;
        o_fx.hung   = w_hung;
        o_fx.lstart = w_ls;
        o_fx.rstart = w_rs;
        o_fx.we_m1  = w_ls;
        o_fx.we_p2  = w_rs;
        o_fx.we     = w_we;
        o_fx.v      = w_v;
        o_fx.own    = w_own;
    end

endmodule

FILE: rtl/dpa_table.sv
// Diner and resource table: state registers, per-diner lanes and merge.
// Uses dpa_pkg and dpa_lane.
module dpa_table
    import dpa_pkg::*;
#(
    parameter int DINERS = DINERS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_wr_data,
    input  logic             i_step_en,
    input  logic [IDX_W-1:0] i_idx,
    output t_result          o_res
);

    logic [1:0]       r_strategy;
    logic [1:0]       r_st  [DINERS];
    logic             r_ov  [DINERS];
    logic [OWN_W-1:0] r_own [DINERS];
    logic [1:0]       n_st  [DINERS];
    logic             n_ov  [DINERS];
    logic [OWN_W-1:0] n_own [DINERS];

    t_lane_fx          w_fx [DINERS];
    logic [DINERS-1:0] w_hit;
    logic              w_in_range;
    logic [DINERS-1:0] w_hungry, w_held, w_cur_eat, w_cur_held;
    logic [MASK_W-1:0] w_emask, w_hmask;
    logic              w_clear;

    assign w_in_range = ({2'b00, i_idx} < 5'(DINERS));
    assign w_clear    = i_cfg_wr_en && (i_cfg_wr_data != STRAT_INVALID);

    for (genvar j = 0; j < DINERS; j++) begin : g_diner
        localparam int JL = (j + DINERS - 1) % DINERS;
        localparam int JR = (j + 1) % DINERS;
        logic [4:0][1:0] w_nb;

        for (genvar o = 0; o < 5; o++) begin : g_nb
            assign w_nb[o] = r_st[(j + 2 * DINERS - 2 + o) % DINERS];
        end

        assign w_hit[j] = w_in_range && ({1'b0, i_idx} == (IDX_W + 1)'(j));

        dpa_lane #(
            .DINERS (DINERS),
            .LANE   (j)
        ) u_lane (
            .i_strategy (r_strategy),
            .i_st_nb    (w_nb),
            .i_ov       ({r_ov[JR], r_ov[j]}),
            .i_own      ({r_own[JR], r_own[j]}),
            .o_fx       (w_fx[j])
        );

        always_comb begin
            if (w_hit[j]) begin
                n_st[j] = w_fx[j].st;
            end else if (w_hit[JR] && w_fx[JR].lstart) begin
                n_st[j] = ST_EATING;
            end else if (w_hit[JL] && w_fx[JL].rstart) begin
                n_st[j] = ST_EATING;
            end else begin
                n_st[j] = r_st[j];
            end
        end

        assign w_hungry[j]   = (n_st[j] == ST_HUNGRY);
        assign w_held[j]     = n_ov[j];
        assign w_cur_eat[j]  = (r_st[j] == ST_EATING);
        assign w_cur_held[j] = r_ov[j];

        // eating diners never sit side by side
        a_no_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            !(r_st[j] == ST_EATING && r_st[JR] == ST_EATING))
            else $error("adjacent diners eating");

        // an eating diner owns both of its resources
        a_eat_owns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_st[j] == ST_EATING) |->
            (r_ov[j] && r_own[j] == OWN_W'(j) && r_ov[JR] && r_own[JR] == OWN_W'(j)))
            else $error("eating diner lacks a resource");
    end

    // resource k: left slot of diner k, right slot of diner k-1,
    // or taken by a neighbour that starts after diner k+1 or k-2 releases
    for (genvar k = 0; k < DINERS; k++) begin : g_res
        localparam int KM1 = (k + DINERS - 1) % DINERS;
        localparam int KP1 = (k + 1) % DINERS;
        localparam int KM2 = (k + DINERS - 2) % DINERS;

        always_comb begin
            n_ov[k]  = r_ov[k];
            n_own[k] = r_own[k];
            if (w_hit[k] && w_fx[k].we[0]) begin
                n_ov[k]  = w_fx[k].v[0];
                n_own[k] = w_fx[k].own[0];
            end else if (w_hit[KM1] && w_fx[KM1].we[1]) begin
                n_ov[k]  = w_fx[KM1].v[1];
                n_own[k] = w_fx[KM1].own[1];
            end else if (w_hit[KP1] && w_fx[KP1].we_m1) begin
                n_ov[k]  = 1'b1;
                n_own[k] = OWN_W'(k);
            end else if (w_hit[KM2] && w_fx[KM2].we_p2) begin
                n_ov[k]  = 1'b1;
                n_own[k] = OWN_W'(KM1);
            end
        end
    end

    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < DINERS) begin : g_on
            assign w_emask[b] = (n_st[b] == ST_EATING);
            assign w_hmask[b] = n_ov[b];
        end else begin : g_off
            assign w_emask[b] = 1'b0;
            assign w_hmask[b] = 1'b0;
        end
    end

    always_comb begin
        o_res = '0;
        for (int k = 0; k < DINERS; k++) begin
            if (w_hit[k]) begin
                o_res.st     = w_fx[k].st;
                o_res.oc     = w_fx[k].oc;
                o_res.hung   = w_fx[k].hung;
                o_res.lstart = w_fx[k].lstart;
                o_res.rstart = w_fx[k].rstart;
            end
        end
        o_res.emask = w_emask;
        o_res.hmask = w_hmask;
        o_res.dead  = (&w_hungry) && (&w_held);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= STRAT_NAIVE;
            for (int k = 0; k < DINERS; k++) begin
                r_st[k]  <= ST_THINKING;
                r_ov[k]  <= 1'b0;
                r_own[k] <= '0;
            end
        end else if (w_clear) begin
            r_strategy <= i_cfg_wr_data;
            for (int k = 0; k < DINERS; k++) begin
                r_st[k]  <= ST_THINKING;
                r_ov[k]  <= 1'b0;
                r_own[k] <= '0;
            end
        end else if (i_step_en) begin
            r_st  <= n_st;
            r_ov  <= n_ov;
            r_own <= n_own;
        end
    end

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (w_cur_eat == '0 && w_cur_held == '0))
        else $error("table not cleared by strategy write");

endmodule

FILE: rtl/dining_philosophers_allocator.sv
// Dining philosophers allocator, top level: request register, table, result register.
// Each accepted request moves from the request register through the table into the result register;
// throughput is 1 request per cycle while the result stream is not stalled.
// Synchronous active-low reset: all diners thinking, all resources free, strategy naive.
// Uses dpa_pkg and dpa_table.
module dining_philosophers_allocator
    import dpa_pkg::*;
#(
    parameter int DINERS = DINERS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [1:0]             i_cfg_wr_data,   // strategy
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,       // [2:0] diner_index
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [1:0] new_diner_state, [4:2] outcome, [5] became_hungry,
    // [6] left_neighbour_started, [7] right_neighbour_started,
    // [12:8] eating_mask, [17:13] held_mask, [18] deadlocked
    output logic [TDATA_OUT_W-1:0] o_m_tdata
);

    logic             r_in_valid;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_result          r_res;
    t_result          w_res;
    logic             w_fire;

    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_OUT_W'(r_res);

    dpa_table #(
        .DINERS (DINERS)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step_en     (w_fire),
        .i_idx         (r_idx),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_idx <= i_s_tdata[IDX_W-1:0];
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

endmodule

FILE: verif/tb_dining_philosophers_allocator.sv
// Testbench for dining_philosophers_allocator: drives diner requests over the slave stream,
// tracks the table in its own predictor and checks every result on the master stream.
// Depends on rtl/dpa_pkg.sv and the allocator RTL.
module tb_dining_philosophers_allocator;
    import dpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DINERS      = DINERS_DEF;
    localparam int STALL_LIMIT = 4000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [1:0]             i_cfg_wr_data = STRAT_NAIVE;
    logic                   i_s_tvalid    = 1'b0;
    logic                   o_s_tready;
    logic [TDATA_IN_W-1:0]  i_s_tdata     = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready    = 1'b0;
    logic [TDATA_OUT_W-1:0] o_m_tdata;

    dining_philosophers_allocator #(.DINERS(DINERS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    // predicted table
    logic [1:0] seat_state [DINERS];
    logic [3:0] res_owner  [DINERS];
    bit         res_taken  [DINERS];
    logic [1:0] cur_strategy;

    t_result outcome_q[$];
    int      n_errors      = 0;
    int      src_idle_pct  = 15;
    int      snk_idle_pct  = 78;
    int      quiet_cycles  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int left_seat(int d);
        return (d + DINERS - 1) % DINERS;
    endfunction

    function automatic int right_seat(int d);
        return (d + 1) % DINERS;
    endfunction

    function automatic void clear_table();
        for (int k = 0; k < DINERS; k++) begin
            seat_state[k] = ST_THINKING;
            res_owner[k]  = '0;
            res_taken[k]  = 1'b0;
        end
    endfunction

    function automatic void grab(int r, int d);
        res_owner[r] = d[3:0];
        res_taken[r] = 1'b1;
    endfunction

    function automatic bit try_arbiter(int d);
        if (seat_state[d] == ST_HUNGRY && seat_state[left_seat(d)] != ST_EATING &&
            seat_state[right_seat(d)] != ST_EATING) begin
            seat_state[d] = ST_EATING;
            grab(d, d);
            grab(right_seat(d), d);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [2:0] try_ordered(int d, int first, int second);
        if (!(res_taken[first] && res_owner[first] == d[3:0])) begin
            if (res_taken[first])
                return OC_FIRST_BUSY;
            grab(first, d);
        end
        if (!res_taken[second]) begin
            grab(second, d);
            seat_state[d] = ST_EATING;
            return OC_STARTED;
        end
        return OC_WAITS_SECOND;
    endfunction

    function automatic t_result predict_request(logic [2:0] idx);
        t_result r;
        int      d;
        int      n_hungry;
        int      n_eating;
        int      n_held;
        r = '0;
        n_hungry = 0;
        n_eating = 0;
        n_held   = 0;
        if (idx < DINERS) begin
            d = idx;
            if (seat_state[d] == ST_EATING) begin
                seat_state[d] = ST_THINKING;
                res_taken[d] = 1'b0;
                res_owner[d] = '0;
                res_taken[right_seat(d)] = 1'b0;
                res_owner[right_seat(d)] = '0;
                r.oc = OC_RELEASED;
                if (cur_strategy == STRAT_ARB) begin
                    r.lstart = try_arbiter(left_seat(d));
                    r.rstart = try_arbiter(right_seat(d));
                end
            end else begin
                if (seat_state[d] == ST_THINKING) begin
                    seat_state[d] = ST_HUNGRY;
                    r.hung = 1'b1;
                end
                if (cur_strategy == STRAT_ARB)
                    r.oc = try_arbiter(d) ? OC_STARTED : OC_REFUSED;
                else if (cur_strategy == STRAT_ASYM && d[0])
                    r.oc = try_ordered(d, right_seat(d), d);
                else
                    r.oc = try_ordered(d, d, right_seat(d));
            end
            r.st = seat_state[d];
        end
        for (int k = 0; k < DINERS; k++) begin
            if (seat_state[k] == ST_HUNGRY)
                n_hungry++;
            if (seat_state[k] == ST_EATING) begin
                n_eating++;
                if (k < MASK_W)
                    r.emask[k] = 1'b1;
            end
            if (res_taken[k]) begin
                n_held++;
                if (k < MASK_W)
                    r.hmask[k] = 1'b1;
            end
        end
        r.dead = (n_hungry == DINERS && n_eating == 0 && n_held == DINERS);
        return r;
    endfunction

    // caller sits at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_request(input logic [2:0] idx);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {{(TDATA_IN_W-IDX_W){1'b0}}, idx};
        do @(posedge i_clk); while (!o_s_tready);
        outcome_q.push_back(predict_request(idx));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_strategy(input logic [1:0] value);
        wait_drained();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        if (value != STRAT_INVALID) begin
            cur_strategy = value;
            clear_table();
        end
    endtask

    task automatic send_list(input int seats[]);
        foreach (seats[i])
            send_request(seats[i][2:0]);
    endtask

    // everyone ends up holding the left resource and waiting for the right one
    task automatic test_naive_deadlock();
        send_list('{4, 3, 2, 1, 0, 4, 0, 4, 3});
    endtask

    // out-of-range requests leave the deadlocked table as it is
    task automatic test_out_of_range();
        send_list('{5, 6, 7});
    endtask

    task automatic test_asymmetric();
        write_strategy(STRAT_ASYM);
        send_list('{1, 2, 1, 3, 0});
    endtask

    // strategy three is dropped: asymmetric order and table survive
    task automatic test_ignored_strategy();
        write_strategy(STRAT_INVALID);
        send_list('{3, 1});
    endtask

    // release of diner 0 lets both hungry neighbours start
    task automatic test_neighbour_check();
        write_strategy(STRAT_ARB);
        send_list('{0, 1, 4, 0});
    endtask

    task automatic test_random(input int n_items, input logic [1:0] first_strategy,
                               input int src_pct, input int snk_pct);
        int sent;
        int chunk;
        sent = 0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_strategy(first_strategy);
        while (sent < n_items) begin
            if (sent != 0)
                write_strategy(2'($urandom_range(3)));
            chunk = $urandom_range(100, 200);
            for (int i = 0; i < chunk && sent < n_items; i++) begin
                if ($urandom_range(9) == 0)
                    send_request(3'($urandom_range(7, DINERS)));
                else
                    send_request(3'($urandom_range(DINERS - 1)));
                sent++;
            end
        end
        wait_drained();
    endtask

    always @(negedge i_clk)
        i_m_tready = ($urandom_range(99) >= snk_idle_pct);

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[$bits(t_result)-1:0]);
            if (outcome_q.size() == 0) begin
                $error("result with no request outstanding: %h", o_m_tdata);
                n_errors++;
            end else begin
                want = outcome_q.pop_front();
                check_field("new_diner_state", want.st, got.st);
                check_field("outcome", want.oc, got.oc);
                check_field("became_hungry", want.hung, got.hung);
                check_field("left_neighbour_started", want.lstart, got.lstart);
                check_field("right_neighbour_started", want.rstart, got.rstart);
                check_field("eating_mask", want.emask, got.emask);
                check_field("held_mask", want.hmask, got.hmask);
                check_field("deadlocked", want.dead, got.dead);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        cur_strategy = STRAT_NAIVE;
        clear_table();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_naive_deadlock();
        test_out_of_range();
        test_asymmetric();
        test_ignored_strategy();
        test_neighbour_check();
        test_random(610, STRAT_NAIVE, 15, 78);
        test_random(610, STRAT_ARB, 78, 15);
        test_random(610, STRAT_ASYM, 0, 0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            $error("%0d results never arrived", outcome_q.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
